### design/rllm_pkg.sv
// ----------------------------------------------------------------------------
// rllm_pkg: shared types and constants for the run-length line map
// Field widths, status codes, op codes and the run table entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rllm_pkg;

   localparam int MAX_RUNS_DEF = 1024;

   localparam int LINE_W   = 16;
   localparam int OFFSET_W = 16;
   localparam int STATUS_W = 2;
   localparam int BYTES_W  = OFFSET_W + 1;   // byte count reaches the full offset space

   // op codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // one run: first byte offset and its source line
   typedef struct packed {
      logic [OFFSET_W-1:0] start;
      logic [LINE_W-1:0]   line;
   } run_entry_type;

   // run table port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

### design/rllm_run_mem.sv
// ----------------------------------------------------------------------------
// rllm_run_mem: run table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rllm_run_mem #(
   parameter int DEPTH = rllm_pkg::MAX_RUNS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                   clock,
   input  wire rllm_pkg::mem_ctl_type  ctl,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire rllm_pkg::run_entry_type wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output rllm_pkg::run_entry_type     rd_data
);
   import rllm_pkg::*;

   run_entry_type mem [DEPTH];
   run_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/rllm_ctrl.sv
// ----------------------------------------------------------------------------
// rllm_ctrl: append and binary search sequencer
// Holds run/byte counts, appends runs, walks the run table one probe a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rllm_ctrl #(
   parameter int MAX_RUNS = rllm_pkg::MAX_RUNS_DEF,
   parameter int AW       = $clog2(MAX_RUNS),
   parameter int CW       = $clog2(MAX_RUNS + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_op,
   input  wire logic [rllm_pkg::LINE_W-1:0]      req_src_line,
   input  wire logic [rllm_pkg::OFFSET_W-1:0]    req_query_offset,
   output logic                                  rsp_strobe,
   output logic [rllm_pkg::LINE_W-1:0]           rsp_found_line,
   output logic [rllm_pkg::OFFSET_W-1:0]         rsp_assigned_offset,
   output logic [rllm_pkg::STATUS_W-1:0]         rsp_status,
   output rllm_pkg::mem_ctl_type                 mem_ctl,
   output logic [AW-1:0]                         mem_wr_addr,
   output rllm_pkg::run_entry_type               mem_wr_data,
   output logic [AW-1:0]                         mem_rd_addr,
   input  wire rllm_pkg::run_entry_type          mem_rd_data
);
   import rllm_pkg::*;

   typedef enum logic {S_IDLE, S_SEARCH} state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         run_count_ff, run_count_in;
   logic [BYTES_W-1:0]    byte_count_ff, byte_count_in;
   logic [LINE_W-1:0]     last_line_ff, last_line_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic [OFFSET_W-1:0]   query_ff, query_in;
   logic [LINE_W-1:0]     best_line_ff, best_line_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [LINE_W-1:0]     rsp_line_ff, rsp_line_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  extend_run;
   logic                  refuse;
   logic                  hit;
   logic [CW-1:0]         lo_n, hi_n;
   logic [LINE_W-1:0]     best_n;

   assign accept = start && (state_ff == S_IDLE);

   // append decision: last run's line kept in a register, no table read needed
   assign extend_run = (run_count_ff != '0) && (last_line_ff == req_src_line);
   assign refuse     = byte_count_ff[BYTES_W-1]
                       || (!extend_run && (run_count_ff == CW'(MAX_RUNS)));

   // probe compare on the entry read last cycle
   assign hit    = (mem_rd_data.start <= query_ff);
   assign lo_n   = hit ? (mid_ff + CW'(1)) : lo_ff;
   assign hi_n   = hit ? hi_ff : mid_ff;
   assign best_n = hit ? mem_rd_data.line : best_line_ff;

   always_comb begin
      state_in      = state_ff;
      run_count_in  = run_count_ff;
      byte_count_in = byte_count_ff;
      last_line_in  = last_line_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      query_in      = query_ff;
      best_line_in  = best_line_ff;
      rsp_strobe_in = 1'b0;
      rsp_line_in   = '0;
      rsp_offset_in = '0;
      rsp_status_in = STAT_OK;
      mem_ctl       = '0;
      mem_wr_addr   = run_count_ff[AW-1:0];
      mem_wr_data   = '{start: byte_count_ff[OFFSET_W-1:0], line: req_src_line};
      mem_rd_addr   = mid_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_APPEND) begin
                  rsp_strobe_in = 1'b1;
                  if (refuse) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     rsp_offset_in = byte_count_ff[OFFSET_W-1:0];
                     byte_count_in = byte_count_ff + BYTES_W'(1);
                     if (!extend_run) begin
                        mem_ctl.wr_en = 1'b1;
                        run_count_in  = run_count_ff + CW'(1);
                        last_line_in  = req_src_line;
                     end
                  end
               end else if (run_count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  // first probe at the middle of [0, run_count)
                  lo_in          = '0;
                  hi_in          = run_count_ff;
                  mid_in         = run_count_ff >> 1;
                  query_in       = req_query_offset;
                  best_line_in   = '0;
                  mem_ctl.rd_en  = 1'b1;
                  mem_rd_addr    = mid_in[AW-1:0];
                  state_in       = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            lo_in        = lo_n;
            hi_in        = hi_n;
            best_line_in = best_n;
            if (lo_n < hi_n) begin
               mid_in        = lo_n + ((hi_n - lo_n) >> 1);
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = mid_in[AW-1:0];
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_line_in   = best_n;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_count_ff  <= '0;
         byte_count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_count_ff  <= run_count_in;
         byte_count_ff <= byte_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      last_line_ff  <= last_line_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      query_ff      <= query_in;
      best_line_ff  <= best_line_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                = (state_ff == S_SEARCH);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_found_line      = rsp_line_ff;
   assign rsp_assigned_offset = rsp_offset_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire

### design/run_length_line_map.sv
// ----------------------------------------------------------------------------
// run_length_line_map: byte offset to source line map
// Run-length table of (start offset, line) with append and binary search.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                    | words
//  ---------+------------------------------+----------------------------------
//  request  | start, busy (taken: start&&!busy) | req_op, req_src_line,
//           |                              | req_query_offset
//  response | rsp_strobe (one cycle, no back-pressure) | rsp_found_line,
//           |                              | rsp_assigned_offset, rsp_status
//
//  Append and refused/empty requests finish in the accept cycle; the response
//  word shows on the next cycle and busy never rises.
//  Lookup: one table probe per cycle, at most floor(log2(run_count)) + 1
//  probes (at most 11 probes at 1024 runs); busy is high while probing and
//  the response is strobed in the cycle in which busy falls.
//  The probe loop is set by the table's single registered read port.
//  Reset (synchronous) empties the table by clearing the counts; no sweep.
//  The receiver cannot stall: every response word is taken when strobed.
//
// Table accesses never overlap on one entry: writes happen only on appends in
// the idle cycle, reads only during a lookup, so no forwarding is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_line_map #(
   parameter int MAX_RUNS = rllm_pkg::MAX_RUNS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [rllm_pkg::LINE_W-1:0]   req_src_line,
   input  wire logic [rllm_pkg::OFFSET_W-1:0] req_query_offset,
   output logic                               rsp_strobe,
   output logic [rllm_pkg::LINE_W-1:0]        rsp_found_line,
   output logic [rllm_pkg::OFFSET_W-1:0]      rsp_assigned_offset,
   output logic [rllm_pkg::STATUS_W-1:0]      rsp_status
);
   import rllm_pkg::*;

   localparam int AW = $clog2(MAX_RUNS);        // table address
   localparam int CW = $clog2(MAX_RUNS + 1);    // run count, holds MAX_RUNS

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] mem_wr_addr;
   logic [AW-1:0] mem_rd_addr;
   run_entry_type mem_wr_data;
   run_entry_type mem_rd_data;

   // sequencer: counts, append path, binary search
   rllm_ctrl #(
      .MAX_RUNS (MAX_RUNS),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_src_line        (req_src_line),
      .req_query_offset    (req_query_offset),
      .rsp_strobe          (rsp_strobe),
      .rsp_found_line      (rsp_found_line),
      .rsp_assigned_offset (rsp_assigned_offset),
      .rsp_status          (rsp_status),
      .mem_ctl             (mem_ctl),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data)
   );

   // run table: start offset and line per run, contents undefined until written
   rllm_run_mem #(
      .DEPTH (MAX_RUNS),
      .AW    (AW)
   ) u_run_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
